@@ rtl/core/linear_interp_resampler_unit_assert.svh @@
// Assertion macros for the linear interpolation resampler.
// Used by linear_interp_resampler_unit.sv; no other dependencies.
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LIR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("linear_interp_resampler_unit: assertion failed");
`define LIR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("linear_interp_resampler_unit: assertion failed");
`else
`define LIR_ASSERT(lbl, clk, rstn, prop)
`define LIR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/lir_pkg.sv @@
// Package for the linear interpolation resampler: sizes, codes, state and
// control/status structs. No dependencies.
`timescale 1ns / 1ps

package lir_pkg;

  localparam int DEPTH       = 4096;
  localparam int SAMPLE_BITS = 24;
  localparam int TIME_BITS   = 32;
  localparam int IDX_W       = 16;
  localparam int TCNT_W      = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = (TIME_BITS > TCNT_W) ? TIME_BITS : TCNT_W;

  localparam int AW  = $clog2(DEPTH);       // store address / quotient bits
  localparam int QB  = AW;
  localparam int CW  = $clog2(DEPTH + 1);   // sample count
  localparam int FB  = SAMPLE_BITS + 1;     // sample difference bits
  localparam int NW  = (QB > FB) ? QB : FB; // divider numerator shift
  localparam int ITW = $clog2(NW);
  localparam int MB  = (IDX_W > FB) ? IDX_W : FB;
  localparam int PRW = TIME_BITS + MB;      // shared product
  localparam int PW  = IDX_W + TIME_BITS;   // index * step
  localparam int TW  = PW + 1;              // target time

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } lir_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_START = 3'd0,
    CFG_SRC_STEP  = 3'd1,
    CFG_TGT_START = 3'd2,
    CFG_TGT_STEP  = 3'd3,
    CFG_TGT_COUNT = 3'd4
  } lir_cfg_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BEYOND = 2'd2
  } lir_status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_SUB, S_DCHK, S_DIV1, S_RNG, S_RD0,
    S_RD1, S_V1, S_MUL2, S_PRE2, S_DIV2, S_CALC, S_FIN
  } lir_state_e;

  typedef struct packed {
    logic idle;
    logic mul_idx;
    logic add_t;
    logic sub_t;
    logic div_init1;
    logic div_init2;
    logic div_step;
    logic rng;
    logic rd0;
    logic rd1;
    logic cap_v1;
    logic mul_r;
    logic calc;
    logic fin;
  } lir_ctrl_t;

  typedef struct packed {
    logic query_go;
    logic early;
    logic t_low;
    logic q_big;
    logic q_out;
    logic r_zero;
    logic out_free;
  } lir_stat_t;

endpackage

@@ rtl/core/lir_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/lir_ctrl.sv @@
// Query sequencer for the resampler: state machine and divider step counter.
// Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lir_pkg::lir_stat_t stat_i,
  output lir_pkg::lir_ctrl_t ctrl_o
);

  lir_pkg::lir_state_e state_q, state_d;
  logic [lir_pkg::ITW-1:0] cnt_q, cnt_d;
  logic cnt_zero;

  assign cnt_zero = (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      lir_pkg::S_IDLE: begin
        if (stat_i.query_go) begin
          state_d = stat_i.early ? lir_pkg::S_FIN : lir_pkg::S_MUL;
        end
      end
      lir_pkg::S_MUL:  state_d = lir_pkg::S_ADD;
      lir_pkg::S_ADD:  state_d = lir_pkg::S_SUB;
      lir_pkg::S_SUB:  state_d = stat_i.t_low ? lir_pkg::S_FIN : lir_pkg::S_DCHK;
      lir_pkg::S_DCHK: state_d = stat_i.q_big ? lir_pkg::S_FIN : lir_pkg::S_DIV1;
      lir_pkg::S_DIV1: begin
        if (cnt_zero) begin
          state_d = lir_pkg::S_RNG;
        end
      end
      lir_pkg::S_RNG:  state_d = stat_i.q_out ? lir_pkg::S_FIN : lir_pkg::S_RD0;
      lir_pkg::S_RD0:  state_d = lir_pkg::S_RD1;
      lir_pkg::S_RD1:  state_d = lir_pkg::S_V1;
      lir_pkg::S_V1:   state_d = stat_i.r_zero ? lir_pkg::S_FIN : lir_pkg::S_MUL2;
      lir_pkg::S_MUL2: state_d = lir_pkg::S_PRE2;
      lir_pkg::S_PRE2: state_d = lir_pkg::S_DIV2;
      lir_pkg::S_DIV2: begin
        if (cnt_zero) begin
          state_d = lir_pkg::S_CALC;
        end
      end
      lir_pkg::S_CALC: state_d = lir_pkg::S_FIN;
      lir_pkg::S_FIN: begin
        if (stat_i.out_free) begin
          state_d = lir_pkg::S_IDLE;
        end
      end
      default: state_d = lir_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    case (state_q)
      lir_pkg::S_DCHK: cnt_d = lir_pkg::ITW'(lir_pkg::QB - 1);
      lir_pkg::S_PRE2: cnt_d = lir_pkg::ITW'(lir_pkg::FB - 1);
      lir_pkg::S_DIV1, lir_pkg::S_DIV2: begin
        if (!cnt_zero) begin
          cnt_d = cnt_q - lir_pkg::ITW'(1);
        end
      end
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.idle      = (state_q == lir_pkg::S_IDLE);
    ctrl_o.mul_idx   = (state_q == lir_pkg::S_MUL);
    ctrl_o.add_t     = (state_q == lir_pkg::S_ADD);
    ctrl_o.sub_t     = (state_q == lir_pkg::S_SUB);
    ctrl_o.div_init1 = (state_q == lir_pkg::S_DCHK);
    ctrl_o.div_init2 = (state_q == lir_pkg::S_PRE2);
    ctrl_o.div_step  = (state_q == lir_pkg::S_DIV1) || (state_q == lir_pkg::S_DIV2);
    ctrl_o.rng       = (state_q == lir_pkg::S_RNG);
    ctrl_o.rd0       = (state_q == lir_pkg::S_RD0);
    ctrl_o.rd1       = (state_q == lir_pkg::S_RD1);
    ctrl_o.cap_v1    = (state_q == lir_pkg::S_V1);
    ctrl_o.mul_r     = (state_q == lir_pkg::S_MUL2);
    ctrl_o.calc      = (state_q == lir_pkg::S_CALC);
    ctrl_o.fin       = (state_q == lir_pkg::S_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lir_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/core/linear_interp_resampler_unit.sv @@
// Linear interpolation resampler: clear, load one sample a transfer, or query
// a resampled point. A query's length is set by the one-bit-per-cycle shared
// divider that runs twice (time offset by source step, then difference*fraction
// by source step) and by the two reads of the single sample RAM port; queries
// that fail early (empty buffer, index at or past target_count, time before or
// past the stored signal) skip the later steps. A result sits in an output
// register, so the next item is taken while it waits.
// Depends on lir_pkg, lir_ctrl, lir_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "linear_interp_resampler_unit_assert.svh"

module linear_interp_resampler_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [lir_pkg::IDX_W-1:0]           target_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lir_pkg::SAMPLE_BITS-1:0] value_out_o,
  output logic                                in_range_o,
  output logic [1:0]                          status_o,
  input  logic                                cfg_we_i,
  input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lir_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int SB  = lir_pkg::SAMPLE_BITS;
  localparam int TB  = lir_pkg::TIME_BITS;
  localparam int AW  = lir_pkg::AW;
  localparam int QB  = lir_pkg::QB;
  localparam int CW  = lir_pkg::CW;
  localparam int FB  = lir_pkg::FB;
  localparam int NW  = lir_pkg::NW;
  localparam int MB  = lir_pkg::MB;
  localparam int PRW = lir_pkg::PRW;
  localparam int PW  = lir_pkg::PW;
  localparam int TW  = lir_pkg::TW;

  lir_pkg::lir_ctrl_t ctl;
  lir_pkg::lir_stat_t stat;

  logic [TB-1:0] src_start_q, src_step_q, tgt_start_q, tgt_step_q;
  logic [lir_pkg::TCNT_W-1:0] tgt_count_q;
  logic [CW-1:0] count_q;

  logic [lir_pkg::IDX_W-1:0] idx_q;
  logic [PRW-1:0] prod_q, mul_p;
  logic [TB-1:0]  mul_a;
  logic [MB-1:0]  mul_b;
  logic [TW-1:0]  t_q, d_q;
  logic [TB-1:0]  rem_q, r_q;
  logic [NW-1:0]  num_q, quot_q;
  logic [TB:0]    cand;
  logic           ge;
  logic [AW-1:0]  i0_q, i1_q;
  logic           r_zero_q, neg_q;
  logic [FB-1:0]  mag_q, diff;
  logic [SB-1:0]  v0_q, rdata;
  logic [CW-1:0]  last, qx, qp1;

  logic [SB-1:0]  res_val_q;
  logic           res_inr_q;
  logic [1:0]     res_st_q;
  logic           out_valid_q, out_inr_q;
  logic [SB-1:0]  out_val_q;
  logic [1:0]     out_st_q;

  logic in_fire, is_query, is_load, is_clear, empty, over, out_load;

  lir_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctl)
  );

  assign in_ready_o = ctl.idle;
  assign in_fire    = in_valid_i && ctl.idle;
  assign is_query   = (command_i == lir_pkg::CMD_QUERY);
  assign is_load    = (command_i == lir_pkg::CMD_LOAD);
  assign is_clear   = (command_i == lir_pkg::CMD_CLEAR);
  assign empty      = (count_q == '0);
  assign over       = (lir_pkg::TCNT_W'(target_index_i) >= tgt_count_q);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_start_q <= '0;
      src_step_q  <= TB'(1);
      tgt_start_q <= '0;
      tgt_step_q  <= TB'(1);
      tgt_count_q <= lir_pkg::TCNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lir_pkg::CFG_SRC_START: src_start_q <= cfg_data_i[TB-1:0];
        lir_pkg::CFG_SRC_STEP: begin
          src_step_q <= (cfg_data_i[TB-1:0] == '0) ? TB'(1) : cfg_data_i[TB-1:0];
        end
        lir_pkg::CFG_TGT_START: tgt_start_q <= cfg_data_i[TB-1:0];
        lir_pkg::CFG_TGT_STEP:  tgt_step_q  <= cfg_data_i[TB-1:0];
        lir_pkg::CFG_TGT_COUNT: tgt_count_q <= cfg_data_i[lir_pkg::TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sample count; loads past capacity are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire && is_clear) begin
      count_q <= '0;
    end else if (in_fire && is_load && (count_q < CW'(lir_pkg::DEPTH))) begin
      count_q <= count_q + CW'(1);
    end
  end

  lir_ram #(
    .WIDTH (SB),
    .DEPTH (lir_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_fire && is_load && (count_q < CW'(lir_pkg::DEPTH))),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (sample_in_i),
    .re_i    (ctl.rd0 || ctl.rd1),
    .raddr_i (ctl.rd1 ? i1_q : i0_q),
    .rdata_o (rdata)
  );

  // shared multiplier
  assign mul_a = ctl.mul_r ? r_q : tgt_step_q;
  assign mul_b = ctl.mul_r ? MB'(mag_q) : MB'(idx_q);
  assign mul_p = PRW'(mul_a) * PRW'(mul_b);

  // shared restoring divider step by source step
  assign cand = {rem_q, num_q[NW-1]};
  assign ge   = (cand >= {1'b0, src_step_q});

  assign last = count_q - CW'(1);
  assign qx   = CW'(quot_q[QB-1:0]);
  assign qp1  = qx + CW'(1);
  assign diff = {rdata[SB-1], rdata} - {v0_q[SB-1], v0_q};

  always_ff @(posedge clk_i) begin
    if (in_fire && is_query) begin
      idx_q     <= target_index_i;
      res_val_q <= '0;
      res_inr_q <= 1'b0;
      res_st_q  <= empty ? lir_pkg::ST_EMPTY : (over ? lir_pkg::ST_BEYOND : lir_pkg::ST_OK);
    end
    if (ctl.mul_idx || ctl.mul_r) begin
      prod_q <= mul_p;
    end
    if (ctl.add_t) begin
      t_q <= TW'(prod_q[PW-1:0]) + TW'(tgt_start_q);
    end
    if (ctl.sub_t) begin
      d_q <= t_q - TW'(src_start_q);
    end
    if (ctl.div_init1) begin
      rem_q  <= TB'(d_q >> QB);
      num_q  <= NW'(d_q[QB-1:0]) << (NW - QB);
      quot_q <= '0;
    end else if (ctl.div_init2) begin
      rem_q  <= TB'(prod_q >> FB);
      num_q  <= NW'(prod_q[FB-1:0]) << (NW - FB);
      quot_q <= '0;
    end else if (ctl.div_step) begin
      rem_q  <= ge ? TB'(cand - {1'b0, src_step_q}) : TB'(cand);
      num_q  <= num_q << 1;
      quot_q <= {quot_q[NW-2:0], ge};
    end
    if (ctl.rng) begin
      i0_q     <= quot_q[QB-1:0];
      i1_q     <= (qp1 > last) ? last[AW-1:0] : qp1[AW-1:0];
      r_q      <= rem_q;
      r_zero_q <= (rem_q == '0);
    end
    if (ctl.rd1) begin
      v0_q <= rdata;
    end
    if (ctl.cap_v1) begin
      neg_q <= diff[FB-1];
      mag_q <= diff[FB-1] ? (~diff + FB'(1)) : diff;
      if (r_zero_q) begin
        res_val_q <= v0_q;
        res_inr_q <= 1'b1;
      end
    end
    if (ctl.calc) begin
      res_val_q <= neg_q ? (v0_q - quot_q[SB-1:0] - SB'(rem_q != '0))
                         : (v0_q + quot_q[SB-1:0]);
      res_inr_q <= 1'b1;
    end
  end

  always_comb begin
    stat          = '0;
    stat.query_go = in_valid_i && is_query;
    stat.early    = empty || over;
    stat.t_low    = (t_q < TW'(src_start_q));
    stat.q_big    = ((d_q >> QB) >= TW'(src_step_q));
    stat.q_out    = (qx > last) || ((qx == last) && (rem_q != '0));
    stat.r_zero   = r_zero_q;
    stat.out_free = !out_valid_q || out_ready_i;
  end

  // output register
  assign out_load = ctl.fin && stat.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q <= res_val_q;
      out_inr_q <= res_inr_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_val_q;
  assign in_range_o  = out_inr_q;
  assign status_o    = out_st_q;

  `LIR_ASSERT(a_rem_below_step, clk_i, rst_ni, ctl.div_step |-> (rem_q < src_step_q))
  `LIR_ASSERT(a_zero_off_range, clk_i, rst_ni, (out_valid_o && !in_range_o) |-> (value_out_o == '0))
  `LIR_ASSERT(a_status_no_range, clk_i, rst_ni, (out_valid_o && (status_o != lir_pkg::ST_OK)) |-> !in_range_o)
  `LIR_ASSERT_NEXT(a_full_load_drop, clk_i, rst_ni, (in_fire && is_load && (count_q == CW'(lir_pkg::DEPTH))), (count_q == CW'(lir_pkg::DEPTH)))

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for linear_interp_resampler_unit: clear/load/query transfers
// and register writes, with every query result predicted and compared field by field.
// Depends on lir_pkg and the resampler RTL.

module testbench;
  import lir_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_OFF       = 300;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          in_range;
    lir_status_e                   status;
  } point_t;

  class interp_tracker;
    logic signed [SAMPLE_BITS-1:0] samples [DEPTH];
    int unsigned  fill;
    logic [TIME_BITS-1:0] src_start, src_step, tgt_start, tgt_step;
    logic [TCNT_W-1:0]    tgt_count;
    point_t       pending_points[$];
    int           mismatches, checked, taken;

    function new();
      fill       = 0;
      src_start  = '0;
      src_step   = 1;
      tgt_start  = '0;
      tgt_step   = 1;
      tgt_count  = 1;
      mismatches = 0;
      checked    = 0;
      taken      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_SRC_START: src_start = data[TIME_BITS-1:0];
        CFG_SRC_STEP:  src_step  = data[TIME_BITS-1:0];
        CFG_TGT_START: tgt_start = data[TIME_BITS-1:0];
        CFG_TGT_STEP:  tgt_step  = data[TIME_BITS-1:0];
        CFG_TGT_COUNT: tgt_count = data[TCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function point_t interpolate(logic [IDX_W-1:0] idx);
      point_t p;
      longint unsigned stp, t, d, q, r, last, i1, mag, prod, frac;
      longint v0, v1, diff, val;
      p.value    = '0;
      p.in_range = 1'b0;
      p.status   = ST_OK;
      if (fill == 0) begin
        p.status = ST_EMPTY;
        return p;
      end
      if ({1'b0, idx} >= tgt_count) begin
        p.status = ST_BEYOND;
        return p;
      end
      stp = (src_step == '0) ? 64'd1 : 64'(src_step);
      t = 64'(idx) * 64'(tgt_step) + 64'(tgt_start);
      if (t < 64'(src_start)) return p;
      d    = t - 64'(src_start);
      q    = d / stp;
      r    = d % stp;
      last = 64'(fill) - 1;
      if (q > last || (q == last && r != 0)) return p;
      i1  = (q + 1 > last) ? last : q + 1;
      v0  = samples[q];
      v1  = samples[i1];
      val = v0;
      if (r != 0) begin
        diff = v1 - v0;
        mag  = (diff < 0) ? -diff : diff;
        prod = mag * r;
        frac = prod / stp;
        if (diff < 0) val = v0 - signed'(frac) - ((prod % stp != 0) ? 1 : 0);
        else           val = v0 + signed'(frac);
      end
      p.value    = val[SAMPLE_BITS-1:0];
      p.in_range = 1'b1;
      return p;
    endfunction

    function void take_item(logic [1:0] cmd, logic signed [SAMPLE_BITS-1:0] smp,
                            logic [IDX_W-1:0] idx);
      taken++;
      case (cmd)
        CMD_CLEAR: fill = 0;
        CMD_LOAD: begin
          if (fill < DEPTH) begin
            samples[fill] = smp;
            fill++;
          end
        end
        CMD_QUERY: pending_points.push_back(interpolate(idx));
        default: ;
      endcase
    endfunction

    function void check_point(logic signed [SAMPLE_BITS-1:0] value, logic in_range,
                              logic [1:0] status);
      point_t want;
      if (pending_points.size() == 0) begin
        $error("result with no query outstanding: value_out %0d", value);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      checked++;
      if (value !== want.value) begin
        $error("value_out: expected %0d, actual %0d", want.value, value);
        mismatches++;
      end
      if (in_range !== want.in_range) begin
        $error("in_range: expected %0d, actual %0d", want.in_range, in_range);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [1:0]                    command_i;
  logic signed [SAMPLE_BITS-1:0] sample_in_i;
  logic [IDX_W-1:0]              target_index_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [SAMPLE_BITS-1:0] value_out_o;
  logic                          in_range_o;
  logic [1:0]                    status_o;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CFG_W-1:0]              cfg_data_i;

  interp_tracker tracker;
  bit sender_idles;
  bit receiver_idles;
  int hold_cycles;
  int settings_run;
  int quiet_cycles;

  linear_interp_resampler_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .sample_in_i    (sample_in_i),
    .target_index_i (target_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_out_o    (value_out_o),
    .in_range_o     (in_range_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // transfer monitor, register-write tap and watchdog
  always @(posedge clk_i) begin
    quiet_cycles++;
    if (rst_ni) begin
      if (cfg_we_i) begin
        tracker.set_reg(cfg_index_i, cfg_data_i);
        quiet_cycles = 0;
      end
      if (in_valid_i && in_ready_o) begin
        tracker.take_item(command_i, sample_in_i, target_index_i);
        quiet_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_point(value_out_o, in_range_o, status_o);
        quiet_cycles = 0;
      end
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_BITS'(signed'(raw[7:0]));
      default: return raw[SAMPLE_BITS-1:0];
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int unsigned count);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (count == 0 || roll < 2) return IDX_W'($urandom);
    if (roll == 2) return (count > 65535) ? 16'hFFFF : IDX_W'(count);
    return IDX_W'($urandom_range(0, count - 1));
  endfunction

  task automatic send_item(logic [1:0] cmd, logic signed [SAMPLE_BITS-1:0] smp,
                           logic [IDX_W-1:0] idx);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    sample_in_i    <= smp;
    target_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic load(logic signed [SAMPLE_BITS-1:0] smp);
    send_item(CMD_LOAD, smp, IDX_W'($urandom));
  endtask

  task automatic query(logic [IDX_W-1:0] idx);
    send_item(CMD_QUERY, rand_sample(), idx);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_points.size() != 0);
  endtask

  // idle block: clears and loads give no result, so allow for one still in flight
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(lir_cfg_e idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [31:0] ss, logic [31:0] sst, logic [31:0] tst,
                               logic [31:0] tsp, logic [31:0] tc);
    write_reg(CFG_SRC_START, ss);
    write_reg(CFG_SRC_STEP, sst);
    write_reg(CFG_TGT_START, tst);
    write_reg(CFG_TGT_STEP, tsp);
    write_reg(CFG_TGT_COUNT, tc);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  task automatic random_phase(int n_items);
    int unsigned     n_load, tc, off, roll;
    logic [31:0]     ss, sst, tst, tsp;
    longint unsigned span, ts;
    n_load = $urandom_range(2, 40);
    roll   = $urandom_range(0, 11);
    if (roll == 0)     sst = '0;
    else if (roll < 5) sst = $urandom_range(1, 16);
    else if (roll < 9) sst = $urandom_range(17, 100000);
    else               sst = $urandom;
    ss   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    tc   = $urandom_range(1, 48);
    span = 64'(n_load) * ((sst == '0) ? 64'd1 : 64'(sst));
    ts   = span / tc + $urandom_range(0, 2);
    if (ts > 64'hFFFF_FFFF) ts = 64'hFFFF_FFFF;
    tsp  = ($urandom_range(0, 9) == 0) ? 32'd0 : ts[31:0];
    off  = $urandom_range(0, 20);
    tst  = (ss > off) ? ss - off : 32'd0;
    if ($urandom_range(0, 7) == 0) tst = $urandom;
    settle();
    apply_setting(ss, sst, tst, tsp, tc);
    send_item(CMD_CLEAR, rand_sample(), IDX_W'($urandom));
    repeat (n_load) load(rand_sample());
    repeat (n_items - n_load - 1) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) query(pick_index(tc));
      else if (roll < 90) load(rand_sample());
      else if (roll < 94) send_item(CMD_UNUSED, rand_sample(), IDX_W'($urandom));
      else if (roll < 97) begin
        send_item(CMD_CLEAR, rand_sample(), IDX_W'($urandom));
        repeat ($urandom_range(1, n_load)) load(rand_sample());
      end else query(IDX_W'($urandom));
    end
  endtask

  initial begin
    tracker        = new();
    hold_cycles    = 0;
    settings_run   = 0;
    quiet_cycles   = 0;
    sender_idles   = 1'b0;
    receiver_idles = 1'b1;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    command_i      <= CMD_CLEAR;
    sample_in_i    <= '0;
    target_index_i <= '0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CFG_SRC_START;
    cfg_data_i     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, exact grid point, edges of the stored signal
    apply_setting(32'd100, 32'd10, 32'd95, 32'd7, 32'd20);
    query(16'hFFFF);
    send_item(CMD_UNUSED, SAMPLE_MAX, 16'hFFFF);
    load(SAMPLE_MAX);
    load(SAMPLE_MIN);
    load('1);
    load('0);
    load(24'sd1000);
    query(0);
    query(1);
    query(2);
    query(5);
    query(6);
    query(7);
    query(19);
    query(20);
    query(16'hFFFF);
    send_item(CMD_CLEAR, '0, '0);
    query(0);
    load(rand_sample());
    query(0);

    // zero source and target steps: every point at the same time
    sender_idles = 1'b1;
    settle();
    apply_setting(32'd5, 32'd0, 32'd7, 32'd0, 32'd3);
    send_item(CMD_CLEAR, '0, '0);
    load(rand_sample());
    load(rand_sample());
    query(0);
    load(rand_sample());
    query(1);
    query(2);
    query(3);
    load(rand_sample());
    query(0);

    // target count masked down to zero
    settle();
    apply_setting(32'd0, 32'd1, 32'd0, 32'd1, 32'hFFFE_0000);
    query(0);
    send_item(CMD_CLEAR, '0, '0);
    query(0);
    load(rand_sample());
    query(16'hFFFF);

    // widest times and steps
    sender_idles = 1'b1;
    settle();
    apply_setting('1, '1, '1, 32'hFFFF_FFFE, 32'h0001_0000);
    send_item(CMD_CLEAR, '0, '0);
    repeat (30) load(rand_sample());
    repeat (40) query(pick_index(40));
    query(16'hFFFF);

    // back-pressure: hold results while queries keep coming, then drain
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    settle();
    apply_setting(32'd0, 32'd3, 32'd1, 32'd2, 32'd30);
    send_item(CMD_CLEAR, '0, '0);
    repeat (12) load(rand_sample());
    hold_cycles = HOLD_OFF;
    repeat (20) query(pick_index(30));
    drain();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    repeat (20) query(pick_index(30));

    for (int ph = 0; ph < 20; ph++) begin
      if (ph >= 16) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end else begin
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
      end
      random_phase(70);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.pending_points.size() != 0) begin
      $error("%0d expected results never arrived", tracker.pending_points.size());
      tracker.mismatches++;
    end
    $display("Run covered %0d accepted items and %0d checked results over %0d settings,",
             tracker.taken, tracker.checked, settings_run);
    $display("including zero steps, widest times and a long output stall.");
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
